### src/fbds_pkg.sv
`default_nettype none

package fbds_pkg;

    localparam int unsigned MAX_MUL_DEFAULT = 15;
    localparam logic [31:0] CLOCK_HZ_RESET  = 32'd12000000;
    localparam logic [16:0] ERR_SCALE       = 17'd100000;

    typedef struct packed {
        logic [35:0] num;
        logic [4:0]  ma;
        logic [23:0] baud;
        logic [3:0]  mul;
        logic [3:0]  add;
        logic        first;
        logic        last;
    } side_a_t;

    typedef struct packed {
        logic [35:0] num;
        logic [28:0] dv;
        logic [23:0] baud;
        logic [3:0]  mul;
        logic [3:0]  add;
        logic        first;
        logic        last;
    } side_b_t;

    typedef struct packed {
        logic [28:0] dv;
        logic [28:0] rbaud;
        logic [3:0]  mul;
        logic [3:0]  add;
        logic        first;
        logic        last;
    } side_c_t;

endpackage

`default_nettype wire

### src/fbds_div.sv
`default_nettype none

module fbds_div #(
    parameter int unsigned NW = 37,
    parameter int unsigned DW = 33,
    parameter int unsigned SW = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] in_num,
    input  wire logic [DW-1:0] in_den,
    input  wire logic [SW-1:0] in_side,
    output logic               out_valid,
    output logic [NW-1:0]      out_quot,
    output logic [SW-1:0]      out_side
);

    logic [NW-1:0] vld_reg;
    logic [DW-1:0] rem_reg  [NW];
    logic [NW-1:0] quo_reg  [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [SW-1:0] side_reg [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DW-1:0] r_in;
        logic [NW-1:0] n_in;
        logic [DW-1:0] d_in;
        logic [SW-1:0] s_in;
        logic          v_in;
        logic [DW:0]   t;
        logic [DW:0]   t_sub;
        logic          ge;

        if (k == 0) begin : g_first
            assign r_in = '0;
            assign n_in = in_num;
            assign d_in = in_den;
            assign s_in = in_side;
            assign v_in = in_valid;
        end
        else begin : g_next
            assign r_in = rem_reg[k-1];
            assign n_in = quo_reg[k-1];
            assign d_in = den_reg[k-1];
            assign s_in = side_reg[k-1];
            assign v_in = vld_reg[k-1];
        end

        assign t     = {r_in, n_in[NW-1]};
        assign ge    = t >= {1'b0, d_in};
        assign t_sub = t - {1'b0, d_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? t_sub[DW-1:0] : t[DW-1:0];
                quo_reg[k]  <= {n_in[NW-2:0], ge};
                den_reg[k]  <= d_in;
                side_reg[k] <= s_in;
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign out_quot  = quo_reg[NW-1];
    assign out_side  = side_reg[NW-1];

endmodule

`default_nettype wire

### src/fractional_baud_divider_search.sv
// Channel   Direction  Handshake          Payload
// s_axis    in         s_tvalid/s_tready  s_tdata: baud_rate
// m_axis    out        m_tvalid/m_tready  m_tdata: divisor, multiplier, divide_add,
//                                                  real_baud, baud_error
// cfg       in         cfg_we             cfg_wdata: clock_hz
//
// Each request issues MAX_MULTIPLIER*(MAX_MULTIPLIER+1)/2 candidate pairs (120 at the
// default), one per cycle unless the pipeline holds; the next request is accepted once
// all candidate pairs have been issued. Most of the pipeline lies in three bit-per-stage
// dividers of 37, 37 and 47 stages.
// Reset restores clock_hz to 12 MHz and empties the pipeline.
// When a result waits and m_tready is low, the whole pipeline holds.
`default_nettype none

module fractional_baud_divider_search #(
    parameter int unsigned MAX_MULTIPLIER = fbds_pkg::MAX_MUL_DEFAULT
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [31:0]  cfg_wdata,    // clock_hz
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [23:0]  s_tdata,      // baud_rate
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata       // divisor, multiplier, divide_add, real_baud,
                                            // baud_error, zero fill
);

    localparam int unsigned SAW = $bits(fbds_pkg::side_a_t);
    localparam int unsigned SBW = $bits(fbds_pkg::side_b_t);
    localparam int unsigned SCW = $bits(fbds_pkg::side_c_t);

    logic        adv;
    logic [31:0] clock_reg;

    logic        busy_reg;
    logic [3:0]  mul_reg;
    logic [3:0]  add_reg;
    logic [23:0] baud_reg;
    logic        seq_last;

    logic        s0_vld_reg;
    logic [3:0]  s0_mul_reg;
    logic [3:0]  s0_add_reg;
    logic [23:0] s0_baud_reg;
    logic        s0_first_reg;
    logic        s0_last_reg;
    logic [4:0]  s0_ma;

    logic        s1_vld_reg;
    logic [35:0] s1_num_reg;
    logic [32:0] s1_den_reg;
    fbds_pkg::side_a_t s1_side_reg;

    logic        s2_vld_reg;
    logic [36:0] s2_num_reg;
    logic [32:0] s2_den_reg;
    fbds_pkg::side_a_t s2_side_reg;

    logic           a_vld;
    logic [36:0]    a_quot;
    logic [SAW-1:0] a_side_raw;
    fbds_pkg::side_a_t a_side;
    logic [28:0]    a_dv;

    logic        s3_vld_reg;
    logic [36:0] s3_den_reg;
    fbds_pkg::side_b_t s3_side_reg;

    logic        s4_vld_reg;
    logic [36:0] s4_num_reg;
    logic [36:0] s4_den_reg;
    fbds_pkg::side_b_t s4_side_reg;

    logic           b_vld;
    logic [36:0]    b_quot;
    logic [SBW-1:0] b_side_raw;
    fbds_pkg::side_b_t b_side;
    logic [28:0]    b_real;
    logic [28:0]    b_baud;

    logic        s5_vld_reg;
    logic [28:0] s5_diff_reg;
    logic [23:0] s5_baud_reg;
    fbds_pkg::side_c_t s5_side_reg;

    logic        s6_vld_reg;
    logic [45:0] s6_prod_reg;
    logic [23:0] s6_baud_reg;
    fbds_pkg::side_c_t s6_side_reg;

    logic        s7_vld_reg;
    logic [46:0] s7_num_reg;
    logic [23:0] s7_baud_reg;
    fbds_pkg::side_c_t s7_side_reg;

    logic           c_vld;
    logic [46:0]    c_quot;
    logic [SCW-1:0] c_side_raw;
    fbds_pkg::side_c_t c_side;
    logic [31:0]    c_err;
    logic           take;

    logic [28:0] best_dv_reg;
    logic [3:0]  best_mul_reg;
    logic [3:0]  best_add_reg;
    logic [28:0] best_real_reg;
    logic [31:0] best_err_reg;
    logic [28:0] win_dv;
    logic [3:0]  win_mul;
    logic [3:0]  win_add;
    logic [28:0] win_real;
    logic [31:0] win_err;

    logic        out_vld_reg;
    logic [28:0] out_dv_reg;
    logic [3:0]  out_mul_reg;
    logic [3:0]  out_add_reg;
    logic [28:0] out_real_reg;
    logic [31:0] out_err_reg;

    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = !busy_reg;
    assign seq_last = (add_reg == (mul_reg - 4'd1)) && (mul_reg == 4'(MAX_MULTIPLIER));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg <= fbds_pkg::CLOCK_HZ_RESET;
        end
        else if (cfg_we)
        begin
            clock_reg <= cfg_wdata;
        end
    end

    // Candidate sequencer: multiplier outer, divide-add inner.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mul_reg  <= 4'd1;
            add_reg  <= 4'd0;
        end
        else if (s_tvalid && s_tready)
        begin
            busy_reg <= 1'b1;
            mul_reg  <= 4'd1;
            add_reg  <= 4'd0;
        end
        else if (busy_reg && adv)
        begin
            if (seq_last)
            begin
                busy_reg <= 1'b0;
            end
            else if (add_reg == (mul_reg - 4'd1))
            begin
                mul_reg <= mul_reg + 4'd1;
                add_reg <= 4'd0;
            end
            else
            begin
                add_reg <= add_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            baud_reg <= (s_tdata == 24'd0) ? 24'd1 : s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_vld_reg <= busy_reg;
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= a_vld;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= b_vld;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= s6_vld_reg;
        end
    end

    assign s0_ma  = 5'(s0_mul_reg) + 5'(s0_add_reg);
    assign a_side = fbds_pkg::side_a_t'(a_side_raw);
    assign a_dv   = (a_quot[28:0] == 29'd0) ? 29'd1 : a_quot[28:0];
    assign b_side = fbds_pkg::side_b_t'(b_side_raw);
    assign b_real = b_quot[28:0];
    assign b_baud = 29'(b_side.baud);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_mul_reg   <= mul_reg;
            s0_add_reg   <= add_reg;
            s0_baud_reg  <= baud_reg;
            s0_first_reg <= (mul_reg == 4'd1) && (add_reg == 4'd0);
            s0_last_reg  <= seq_last;

            s1_num_reg        <= 36'(clock_reg) * 36'(s0_mul_reg);
            s1_den_reg        <= {29'(s0_baud_reg) * 29'(s0_ma), 4'b0000};
            s1_side_reg.num   <= '0;
            s1_side_reg.ma    <= s0_ma;
            s1_side_reg.baud  <= s0_baud_reg;
            s1_side_reg.mul   <= s0_mul_reg;
            s1_side_reg.add   <= s0_add_reg;
            s1_side_reg.first <= s0_first_reg;
            s1_side_reg.last  <= s0_last_reg;

            s2_num_reg        <= 37'(s1_num_reg) + 37'(s1_den_reg[32:1]);
            s2_den_reg        <= s1_den_reg;
            s2_side_reg.num   <= s1_num_reg;
            s2_side_reg.ma    <= s1_side_reg.ma;
            s2_side_reg.baud  <= s1_side_reg.baud;
            s2_side_reg.mul   <= s1_side_reg.mul;
            s2_side_reg.add   <= s1_side_reg.add;
            s2_side_reg.first <= s1_side_reg.first;
            s2_side_reg.last  <= s1_side_reg.last;

            s3_den_reg        <= {33'(a_dv) * 33'(a_side.ma), 4'b0000};
            s3_side_reg.num   <= a_side.num;
            s3_side_reg.dv    <= a_dv;
            s3_side_reg.baud  <= a_side.baud;
            s3_side_reg.mul   <= a_side.mul;
            s3_side_reg.add   <= a_side.add;
            s3_side_reg.first <= a_side.first;
            s3_side_reg.last  <= a_side.last;

            s4_num_reg  <= 37'(s3_side_reg.num) + 37'(s3_den_reg[36:1]);
            s4_den_reg  <= s3_den_reg;
            s4_side_reg <= s3_side_reg;

            s5_diff_reg       <= (b_baud > b_real) ? (b_baud - b_real) : (b_real - b_baud);
            s5_baud_reg       <= b_side.baud;
            s5_side_reg.dv    <= b_side.dv;
            s5_side_reg.rbaud <= b_real;
            s5_side_reg.mul   <= b_side.mul;
            s5_side_reg.add   <= b_side.add;
            s5_side_reg.first <= b_side.first;
            s5_side_reg.last  <= b_side.last;

            s6_prod_reg <= 46'(s5_diff_reg) * 46'(fbds_pkg::ERR_SCALE);
            s6_baud_reg <= s5_baud_reg;
            s6_side_reg <= s5_side_reg;

            s7_num_reg  <= 47'(s6_prod_reg) + 47'(s6_baud_reg[23:1]);
            s7_baud_reg <= s6_baud_reg;
            s7_side_reg <= s6_side_reg;
        end
    end

    fbds_div #(
        .NW (37),
        .DW (33),
        .SW (SAW)
    ) u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s2_vld_reg),
        .in_num    (s2_num_reg),
        .in_den    (s2_den_reg),
        .in_side   (SAW'(s2_side_reg)),
        .out_valid (a_vld),
        .out_quot  (a_quot),
        .out_side  (a_side_raw)
    );

    fbds_div #(
        .NW (37),
        .DW (37),
        .SW (SBW)
    ) u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s4_vld_reg),
        .in_num    (s4_num_reg),
        .in_den    (s4_den_reg),
        .in_side   (SBW'(s4_side_reg)),
        .out_valid (b_vld),
        .out_quot  (b_quot),
        .out_side  (b_side_raw)
    );

    fbds_div #(
        .NW (47),
        .DW (24),
        .SW (SCW)
    ) u_div_c (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s7_vld_reg),
        .in_num    (s7_num_reg),
        .in_den    (s7_baud_reg),
        .in_side   (SCW'(s7_side_reg)),
        .out_valid (c_vld),
        .out_quot  (c_quot),
        .out_side  (c_side_raw)
    );

    assign c_side = fbds_pkg::side_c_t'(c_side_raw);
    assign c_err  = (c_quot[46:32] != 15'd0) ? 32'hFFFF_FFFF : c_quot[31:0];
    assign take   = c_side.first || (c_err < best_err_reg);

    always_comb
    begin
        if (take)
        begin
            win_dv   = c_side.dv;
            win_mul  = c_side.mul;
            win_add  = c_side.add;
            win_real = c_side.rbaud;
            win_err  = c_err;
        end
        else
        begin
            win_dv   = best_dv_reg;
            win_mul  = best_mul_reg;
            win_add  = best_add_reg;
            win_real = best_real_reg;
            win_err  = best_err_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && c_vld)
        begin
            best_dv_reg   <= win_dv;
            best_mul_reg  <= win_mul;
            best_add_reg  <= win_add;
            best_real_reg <= win_real;
            best_err_reg  <= win_err;
        end
        if (adv && c_vld && c_side.last)
        begin
            out_dv_reg   <= win_dv;
            out_mul_reg  <= win_mul;
            out_add_reg  <= win_add;
            out_real_reg <= win_real;
            out_err_reg  <= win_err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv && c_vld && c_side.last)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, out_err_reg, out_real_reg, out_add_reg, out_mul_reg, out_dv_reg};

endmodule

`default_nettype wire
